/* hdl/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros; empty when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/rdt_pkg.sv */
// -----------------------------------------------------------------------------
// Retry deadline table package
// Sizes, codes and helpers shared by the retry deadline table.
// -----------------------------------------------------------------------------
package rdt_pkg;

    localparam int ENTRIES   = 16;
    localparam int ID_BITS   = 32;
    localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TIME_BITS = 32;

    typedef logic [ID_BITS-1:0]   t_slot_id;
    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [SLOT_BITS-1:0] t_slot_idx;

    typedef enum logic {
        OP_SCHED = 1'b0,
        OP_CHECK = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_DUE   = 2'd0,
        KIND_SCHED = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Low 32 bits of a stored id, zero-extended when ids are narrower
    function automatic logic [31:0] due_id_of(input t_slot_id id);
        logic [63:0] wide;
        wide = 64'(id);
        return wide[31:0];
    endfunction

endpackage

/* hdl/retry_deadline_table_unit.sv */
// -----------------------------------------------------------------------------
// Retry deadline table unit
// Keeps ENTRIES retry deadlines and sweeps them against the current time.
// -----------------------------------------------------------------------------
// A schedule transaction stores its bundle id with deadline now plus the
// retry timeout (saturating) in the lowest free slot and answers with one
// registered result (scheduled, or table full). A check transaction sweeps all
// slots in index order, one slot per cycle (held while a due result waits on
// an output stall) through the single read port of the id/deadline memory,
// emits one retry-due result per expired slot and closes with a done result
// carrying the smallest remaining wait (0 = none). A check blocks new input
// until its done result is issued; a schedule leaves the block idle.
// The timeout register may be written only while no transaction is in work.
`include "assert_macros.svh"

module retry_deadline_table_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [31:0]            i_cfg_wdata,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  rdt_pkg::t_opcode       i_opcode,
    input  logic [31:0]            i_bundle_id,
    input  logic [31:0]            i_now_seconds,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output rdt_pkg::t_kind         o_kind,
    output logic [31:0]            o_due_id,
    output logic [31:0]            o_next_wait,
    output logic                   o_last
);
    import rdt_pkg::*;

    // slot memories
    t_slot_id mem_id [ENTRIES];
    t_time    mem_dl [ENTRIES];

    t_slot_id r_rd_id;
    t_time    r_rd_dl;

    logic      mem_we;
    t_slot_idx wr_addr;
    t_slot_id  wr_id;
    t_time     wr_dl;
    t_slot_idx rd_addr;

    // control and state
    t_state              r_state, n_state;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    t_time               r_min, n_min;
    t_time               r_timeout;
    t_time               r_now, n_now;
    t_slot_idx           r_ev_idx, n_ev_idx;

    // output register
    logic        r_out_vld, n_out_vld;
    t_kind       r_out_kind, n_out_kind;
    logic [31:0] r_out_id, n_out_id;
    t_time       r_out_wait, n_out_wait;
    logic        r_out_last, n_out_last;

    logic      out_free;
    logic      in_acc;
    logic      full;
    t_slot_idx free_idx;
    logic [TIME_BITS:0] dl_sum;
    t_time     new_dl;
    t_time     sched_min;
    logic      slot_live;
    logic      slot_due;
    t_time     rem;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_out_kind;
    assign o_due_id    = r_out_id;
    assign o_next_wait = r_out_wait;
    assign o_last      = r_out_last;

    // lowest free slot
    always_comb begin
        full     = &r_valid;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SLOT_BITS'(i);
            end
        end
    end

    assign dl_sum    = {1'b0, i_now_seconds} + {1'b0, r_timeout};
    assign new_dl    = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
    assign sched_min = ((r_min == '0) || (r_timeout < r_min)) ? r_timeout : r_min;

    assign slot_live = r_valid[r_ev_idx];
    assign slot_due  = slot_live && (r_rd_dl <= r_now);
    assign rem       = r_rd_dl - r_now;

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_min      = r_min;
        n_now      = r_now;
        n_ev_idx   = r_ev_idx;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_kind = r_out_kind;
        n_out_id   = r_out_id;
        n_out_wait = r_out_wait;
        n_out_last = r_out_last;
        mem_we     = 1'b0;
        wr_addr    = free_idx;
        wr_id      = ID_BITS'(i_bundle_id);
        wr_dl      = new_dl;
        rd_addr    = r_ev_idx;

        case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
                if (in_acc) begin
                    if (i_opcode == OP_SCHED) begin
                        n_out_vld  = 1'b1;
                        n_out_id   = '0;
                        n_out_last = 1'b1;
                        if (full) begin
                            n_out_kind = KIND_FULL;
                            n_out_wait = r_min;
                        end else begin
                            mem_we            = 1'b1;
                            n_valid[free_idx] = 1'b1;
                            n_min             = sched_min;
                            n_out_kind        = KIND_SCHED;
                            n_out_wait        = sched_min;
                        end
                    end else begin
                        n_now    = i_now_seconds;
                        n_min    = '0;
                        n_ev_idx = '0;
                        n_state  = ST_SWEEP;
                    end
                end
            end

            ST_SWEEP: begin
                if (slot_due && !out_free) begin
                    // hold: re-read the same slot until the result can go out
                    rd_addr = r_ev_idx;
                end else begin
                    if (slot_due) begin
                        n_valid[r_ev_idx] = 1'b0;
                        n_out_vld         = 1'b1;
                        n_out_kind        = KIND_DUE;
                        n_out_id          = due_id_of(r_rd_id);
                        n_out_wait        = '0;
                        n_out_last        = 1'b0;
                    end else if (slot_live) begin
                        if ((r_min == '0) || (rem < r_min)) begin
                            n_min = rem;
                        end
                    end
                    if (r_ev_idx == SLOT_BITS'(ENTRIES - 1)) begin
                        n_state = ST_DONE;
                    end
                    n_ev_idx = r_ev_idx + 1'b1;
                    rd_addr  = r_ev_idx + 1'b1;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_kind = KIND_DONE;
                    n_out_id   = '0;
                    n_out_wait = r_min;
                    n_out_last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_min     <= '0;
            r_timeout <= 32'd30;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_min     <= n_min;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_ev_idx   <= n_ev_idx;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_wait <= n_out_wait;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_id[wr_addr] <= wr_id;
            mem_dl[wr_addr] <= wr_dl;
        end
        r_rd_id <= mem_id[rd_addr];
        r_rd_dl <= mem_dl[rd_addr];
    end

    `ASSERT_NEXT(a_sched_fills_one, i_clk, i_rst_n, in_acc && (i_opcode == OP_SCHED) && !full, $countones(r_valid) == $countones($past(r_valid)) + 1)
    `ASSERT_NEXT(a_sweep_never_fills, i_clk, i_rst_n, r_state == ST_SWEEP, $countones(r_valid) <= $countones($past(r_valid)))
    `ASSERT_NEXT(a_check_starts_sweep, i_clk, i_rst_n, in_acc && (i_opcode == OP_CHECK), (r_state == ST_SWEEP) && (r_ev_idx == '0))
    `ASSERT_IMP(a_due_not_last, i_clk, i_rst_n, r_out_vld && (r_out_kind == KIND_DUE), !r_out_last && (r_out_wait == '0))
    `ASSERT_IMP(a_closing_is_last, i_clk, i_rst_n, r_out_vld && (r_out_kind != KIND_DUE), r_out_last && (r_out_id == '0))

endmodule
